/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros; they expand to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define HBS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Check that a condition implies another on the same edge.
`define HBS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");

`else

`define HBS_ASSERT(lbl, clk, rst_n, prop)
`define HBS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* sv/hbs_pkg.sv */
// ----------------------------------------------------------------------------
// hbs_pkg
// Widths, command and status codes of the histogram bin sampler.
// ----------------------------------------------------------------------------
package hbs_pkg;

  localparam int unsigned MaxBinsDefault = 64;

  localparam int unsigned EdgeW   = 32;
  localparam int unsigned WeightW = 16;
  localparam int unsigned CountW  = 22;
  localparam int unsigned FracW   = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned BinW    = 6;

  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic [1:0] CmdClear  = 2'd0;
  localparam logic [1:0] CmdAppend = 2'd1;
  localparam logic [1:0] CmdSample = 2'd2;

  localparam logic [StatusW-1:0] StatusOk    = 3'd0;
  localparam logic [StatusW-1:0] StatusDone  = 3'd1;
  localparam logic [StatusW-1:0] StatusEmpty = 3'd2;
  localparam logic [StatusW-1:0] StatusRange = 3'd3;
  localparam logic [StatusW-1:0] StatusFull  = 3'd4;

endpackage

/* sv/histogram_bin_sampler.sv */
// ----------------------------------------------------------------------------
// histogram_bin_sampler
// Clear, append and sample on a histogram table; inverse-CDF binary search.
// Clear, append, unused command and sample errors: result one cycle after start.
// Sample: up to 2*ceil(log2(n+1)) probe cycles plus 2 (last bin) or 4 (interpolated)
// cycles for n bins; each probe is one read of the cumulative-count RAM and
// one compare. busy_o drops with the result, so the next word can start in the
// result cycle; the receiver cannot stall.
// Reset clears the bin count and total; the RAM contents are not cleared.
// ----------------------------------------------------------------------------
module histogram_bin_sampler #(
  parameter int unsigned MAX_BINS = hbs_pkg::MaxBinsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [1:0]                          cmd_i,
  input  logic signed [hbs_pkg::EdgeW-1:0]    bin_left_edge_i,
  input  logic [hbs_pkg::WeightW-1:0]         bin_weight_i,
  input  logic [hbs_pkg::CountW-1:0]          draw_count_i,
  input  logic [hbs_pkg::FracW-1:0]           draw_fraction_i,
  output logic                                done_o,
  output logic [hbs_pkg::StatusW-1:0]         status_o,
  output logic [hbs_pkg::BinW-1:0]            chosen_bin_o,
  output logic signed [hbs_pkg::EdgeW-1:0]    sample_value_o,
  output logic                                open_top_o
);

  `include "assert_macros.svh"

  localparam int unsigned IdxW = $clog2(MAX_BINS);
  localparam int unsigned CntW = $clog2(MAX_BINS + 1);
  localparam int unsigned EW   = hbs_pkg::EdgeW;
  localparam int unsigned CW   = hbs_pkg::CountW;
  localparam int unsigned FW   = hbs_pkg::FracW;
  localparam int unsigned PW   = EW + 1 + FW + 1;
  localparam logic [CntW-1:0] BinsMax = CntW'(MAX_BINS);

  typedef enum logic [2:0] {
    StIdle,
    StProbe,
    StCompare,
    StLeft,
    StNext,
    StMult
  } state_e;

  state_e                        state_q, state_d;
  logic [CntW-1:0]               bins_used_q, bins_used_d;
  logic [CW-1:0]                 total_q, total_d;
  logic [CntW-1:0]               lo_q, lo_d;
  logic [CntW-1:0]               hi_q, hi_d;
  logic [IdxW-1:0]               mid_q, mid_d;
  logic [IdxW-1:0]               bin_q, bin_d;
  logic [CW-1:0]                 draw_q, draw_d;
  logic [FW-1:0]                 frac_q, frac_d;
  logic [EW-1:0]                 left_q, left_d;
  logic signed [PW-1:0]          prod_q, prod_d;
  logic                          done_q, done_d;
  logic [hbs_pkg::StatusW-1:0]   status_q, status_d;
  logic [hbs_pkg::BinW-1:0]      chosen_q, chosen_d;
  logic [EW-1:0]                 value_q, value_d;
  logic                          top_q, top_d;

  logic                          we_w;
  logic [IdxW-1:0]               raddr_w;
  logic [EW-1:0]                 left_rd_w;
  logic [CW-1:0]                 cum_rd_w;
  logic [CW:0]                   sum_w;
  logic [CW-1:0]                 sat_w;
  logic [CntW-1:0]               mid_w;
  logic [CntW-1:0]               final_w;
  logic                          last_w;
  logic signed [EW:0]            diff_w;
  logic signed [PW-1:0]          prod_w;
  logic signed [EW+1:0]          step_w;
  logic signed [EW+1:0]          res_w;

  // Append path: saturating running total.
  assign sum_w = (CW + 1)'(total_q) + (CW + 1)'(bin_weight_i);
  assign sat_w = sum_w[CW] ? hbs_pkg::CountMax : sum_w[CW-1:0];

  assign we_w = (state_q == StIdle) && start_i && (cmd_i == hbs_pkg::CmdAppend) &&
                (bins_used_q < BinsMax);

  // Search step and end-of-search bin, clamped to the last used bin.
  assign mid_w   = lo_q + ((hi_q - lo_q) >> 1);
  assign final_w = (lo_q >= bins_used_q) ? (bins_used_q - 1'b1) : lo_q;
  assign last_w  = ((CntW'(bin_q) + 1'b1) >= bins_used_q);

  always_comb begin
    case (state_q)
      StProbe: raddr_w = (lo_q < hi_q) ? mid_w[IdxW-1:0] : final_w[IdxW-1:0];
      StLeft:  raddr_w = bin_q + 1'b1;
      default: raddr_w = mid_q;
    endcase
  end

  // Interpolation: product registered, then floor shift and add.
  assign diff_w = $signed({left_rd_w[EW-1], left_rd_w}) - $signed({left_q[EW-1], left_q});
  assign prod_w = diff_w * $signed({1'b0, frac_q});
  assign step_w = (EW + 2)'(prod_q >>> FW);
  assign res_w  = $signed({{2{left_q[EW-1]}}, left_q}) + step_w;

  hbs_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_BINS)
  ) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (we_w),
    .waddr_i (bins_used_q[IdxW-1:0]),
    .wdata_i (bin_left_edge_i),
    .raddr_i (raddr_w),
    .rdata_o (left_rd_w)
  );

  hbs_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_BINS)
  ) u_cum_ram (
    .clk_i   (clk_i),
    .we_i    (we_w),
    .waddr_i (bins_used_q[IdxW-1:0]),
    .wdata_i (sat_w),
    .raddr_i (raddr_w),
    .rdata_o (cum_rd_w)
  );

  always_comb begin
    state_d     = state_q;
    bins_used_d = bins_used_q;
    total_d     = total_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    bin_d       = bin_q;
    draw_d      = draw_q;
    frac_d      = frac_q;
    left_d      = left_q;
    prod_d      = prod_q;
    done_d      = 1'b0;
    status_d    = hbs_pkg::StatusDone;
    chosen_d    = '0;
    value_d     = '0;
    top_d       = 1'b0;

    case (state_q)
      StIdle: begin
        if (start_i) begin
          draw_d = draw_count_i;
          frac_d = draw_fraction_i;
          case (cmd_i)
            hbs_pkg::CmdClear: begin
              bins_used_d = '0;
              total_d     = '0;
              done_d      = 1'b1;
            end
            hbs_pkg::CmdAppend: begin
              done_d = 1'b1;
              if (bins_used_q >= BinsMax) begin
                status_d = hbs_pkg::StatusFull;
              end else begin
                total_d     = sat_w;
                bins_used_d = bins_used_q + 1'b1;
              end
            end
            hbs_pkg::CmdSample: begin
              if (bins_used_q == '0) begin
                done_d   = 1'b1;
                status_d = hbs_pkg::StatusEmpty;
              end else if (draw_count_i >= total_q) begin
                done_d   = 1'b1;
                status_d = hbs_pkg::StatusRange;
              end else begin
                lo_d    = '0;
                hi_d    = bins_used_q;
                state_d = StProbe;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      StProbe: begin
        if (lo_q < hi_q) begin
          mid_d   = mid_w[IdxW-1:0];
          state_d = StCompare;
        end else begin
          bin_d   = final_w[IdxW-1:0];
          state_d = StLeft;
        end
      end
      StCompare: begin
        // first bin whose cumulative count exceeds the draw
        if (cum_rd_w > draw_q) begin
          hi_d = CntW'(mid_q);
        end else begin
          lo_d = CntW'(mid_q) + 1'b1;
        end
        state_d = StProbe;
      end
      StLeft: begin
        left_d = left_rd_w;
        if (last_w) begin
          done_d   = 1'b1;
          status_d = hbs_pkg::StatusOk;
          chosen_d = hbs_pkg::BinW'(bin_q);
          value_d  = left_rd_w;
          top_d    = 1'b1;
          state_d  = StIdle;
        end else begin
          state_d = StNext;
        end
      end
      StNext: begin
        prod_d  = prod_w;
        state_d = StMult;
      end
      StMult: begin
        done_d   = 1'b1;
        status_d = hbs_pkg::StatusOk;
        chosen_d = hbs_pkg::BinW'(bin_q);
        value_d  = res_w[EW-1:0];
        state_d  = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      bins_used_q <= '0;
      total_q     <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      bin_q       <= '0;
      draw_q      <= '0;
      frac_q      <= '0;
      left_q      <= '0;
      prod_q      <= '0;
      done_q      <= 1'b0;
      status_q    <= hbs_pkg::StatusDone;
      chosen_q    <= '0;
      value_q     <= '0;
      top_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      bins_used_q <= bins_used_d;
      total_q     <= total_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      mid_q       <= mid_d;
      bin_q       <= bin_d;
      draw_q      <= draw_d;
      frac_q      <= frac_d;
      left_q      <= left_d;
      prod_q      <= prod_d;
      done_q      <= done_d;
      status_q    <= status_d;
      chosen_q    <= chosen_d;
      value_q     <= value_d;
      top_q       <= top_d;
    end
  end

  assign busy_o         = (state_q != StIdle);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign chosen_bin_o   = chosen_q;
  assign sample_value_o = value_q;
  assign open_top_o     = top_q;

  `HBS_ASSERT(a_done_not_busy, clk_i, rst_ni, !(done_o && busy_o))
  `HBS_ASSERT_IMPLY(a_err_zero, clk_i, rst_ni, done_o && (status_o != hbs_pkg::StatusOk),
                    (chosen_bin_o == '0) && (sample_value_o == '0) && !open_top_o)
  `HBS_ASSERT_IMPLY(a_top_ok, clk_i, rst_ni, open_top_o, done_o && (status_o == hbs_pkg::StatusOk))
  `HBS_ASSERT(a_bins_cap, clk_i, rst_ni, bins_used_q <= BinsMax)
  `HBS_ASSERT_IMPLY(a_search_bounds, clk_i, rst_ni, state_q == StProbe, (lo_q <= hi_q) && (hi_q <= bins_used_q))

endmodule

/* sv/hbs_ram.sv */
// ----------------------------------------------------------------------------
// hbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hbs_ram #(
  parameter int unsigned WIDTH = hbs_pkg::EdgeW,
  parameter int unsigned DEPTH = hbs_pkg::MaxBinsDefault
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for histogram_bin_sampler. Tables are built by clear and
// append words, then sampled with draws that land inside, on the cumulative
// boundaries of and beyond the total weight. A scoreboard keeps its own copy
// of the bin table and checks every strobed result in order.
// ----------------------------------------------------------------------------
module testbench;
  import hbs_pkg::*;

  localparam int unsigned TableDepth  = MaxBinsDefault;
  localparam logic [1:0]  CmdUnused   = 2'd3;
  localparam int unsigned WordTarget  = 850;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned PrintCap    = 40;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [BinW-1:0]    bin;
    logic [EdgeW-1:0]   value;
    logic               top;
  } sample_result_t;

  class sampler_scoreboard;
    logic [EdgeW-1:0]  left_tab [TableDepth];
    logic [CountW-1:0] cum_tab [TableDepth];
    int unsigned       used;
    logic [CountW-1:0] total;
    sample_result_t    expected_q[$];
    int unsigned       errors, checked, n_ok, n_top, n_done, n_empty, n_range, n_full;

    function new();
      used  = 0;
      total = '0;
    endfunction

    function sample_result_t predict(logic [1:0] cmd, logic [EdgeW-1:0] left_edge,
                                     logic [WeightW-1:0] weight, logic [CountW-1:0] draw,
                                     logic [FracW-1:0] frac);
      sample_result_t r;
      logic [CountW:0] sum;
      int unsigned lo, hi, mid;
      longint base, diff, prod;
      r = '0;
      r.status = StatusDone;
      case (cmd)
        CmdClear: begin
          used  = 0;
          total = '0;
        end
        CmdAppend: begin
          if (used >= TableDepth) begin
            r.status = StatusFull;
          end else begin
            sum = total + weight;
            if (sum > {1'b0, CountMax}) sum = {1'b0, CountMax};
            total = sum[CountW-1:0];
            left_tab[used] = left_edge;
            cum_tab[used]  = total;
            used++;
          end
        end
        CmdSample: begin
          if (used == 0) begin
            r.status = StatusEmpty;
          end else if (draw >= total) begin
            r.status = StatusRange;
          end else begin
            // first bin whose cumulative weight is strictly above the draw
            lo = 0;
            hi = used;
            while (lo < hi) begin
              mid = lo + (hi - lo) / 2;
              if (cum_tab[mid] > draw) hi = mid;
              else lo = mid + 1;
            end
            if (lo >= used) lo = used - 1;
            r.status = StatusOk;
            r.bin    = lo[BinW-1:0];
            if (lo + 1 >= used) begin
              r.value = left_tab[lo];
              r.top   = 1'b1;
            end else begin
              base    = longint'($signed(left_tab[lo]));
              diff    = longint'($signed(left_tab[lo+1])) - base;
              prod    = diff * longint'(frac);
              r.value = EdgeW'(base + (prod >>> 16));
            end
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_word(logic [1:0] cmd, logic [EdgeW-1:0] left_edge,
                            logic [WeightW-1:0] weight, logic [CountW-1:0] draw,
                            logic [FracW-1:0] frac);
      sample_result_t want;
      want = predict(cmd, left_edge, weight, draw, frac);
      expected_q.insert(expected_q.size(), want);
    endfunction

    function void report(string field, logic [EdgeW-1:0] want, logic [EdgeW-1:0] got);
      errors++;
      if (errors <= PrintCap)
        $display("%0t ns: %s expected %0h, actual %0h", $time, field, want, got);
    endfunction

    function void check_result(logic [StatusW-1:0] status, logic [BinW-1:0] bin,
                               logic [EdgeW-1:0] value, logic top);
      sample_result_t want;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= PrintCap)
          $display("%0t ns: unexpected result, expected none, actual status %0h", $time,
                   status);
        return;
      end
      want = expected_q.pop_front();
      case (want.status)
        StatusOk:    n_ok++;
        StatusDone:  n_done++;
        StatusEmpty: n_empty++;
        StatusRange: n_range++;
        default:     n_full++;
      endcase
      if (want.top && want.status == StatusOk) n_top++;
      if (status !== want.status)
        report("status", EdgeW'(want.status), EdgeW'(status));
      if (bin !== want.bin) report("chosen_bin", EdgeW'(want.bin), EdgeW'(bin));
      if (value !== want.value) report("sample_value", want.value, value);
      if (top !== want.top) report("open_top", EdgeW'(want.top), EdgeW'(top));
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start_i;
  logic                        busy_o;
  logic [1:0]                  cmd_i;
  logic signed [EdgeW-1:0]     bin_left_edge_i;
  logic [WeightW-1:0]          bin_weight_i;
  logic [CountW-1:0]           draw_count_i;
  logic [FracW-1:0]            draw_fraction_i;
  logic                        done_o;
  logic [StatusW-1:0]          status_o;
  logic [BinW-1:0]             chosen_bin_o;
  logic signed [EdgeW-1:0]     sample_value_o;
  logic                        open_top_o;

  sampler_scoreboard sb;
  int unsigned       words_sent;
  int unsigned       quiet_left;
  int unsigned       cycle_count;

  histogram_bin_sampler DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .cmd_i           (cmd_i),
    .bin_left_edge_i (bin_left_edge_i),
    .bin_weight_i    (bin_weight_i),
    .draw_count_i    (draw_count_i),
    .draw_fraction_i (draw_fraction_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .chosen_bin_o    (chosen_bin_o),
    .sample_value_o  (sample_value_o),
    .open_top_o      (open_top_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t ns: timeout, %0d results still outstanding", $time, sb.expected_q.size());
      $display("histogram_bin_sampler: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_result(status_o, chosen_bin_o, sample_value_o, open_top_o);
  end

  // Drive one word from a falling edge and hold it until the block takes it.
  task automatic send_word(input logic [1:0] cmd, input logic [EdgeW-1:0] left_edge,
                           input logic [WeightW-1:0] weight, input logic [CountW-1:0] draw,
                           input logic [FracW-1:0] frac);
    int unsigned gap;
    if (quiet_left > 0) begin
      gap = 0;
      quiet_left--;
    end else begin
      if ($urandom_range(0, 15) == 0) quiet_left = $urandom_range(10, 40);
      gap = $urandom_range(0, 11);
    end
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_i           = cmd;
    bin_left_edge_i = left_edge;
    bin_weight_i    = weight;
    draw_count_i    = draw;
    draw_fraction_i = frac;
    start_i         = 1'b1;
    do @(posedge clk_i); while (busy_o);
    sb.note_word(cmd, left_edge, weight, draw, frac);
    if (cmd != CmdUnused) words_sent++;
    @(negedge clk_i);
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic wait_drain();
    start_i = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic append_bin(input logic [EdgeW-1:0] left_edge, input logic [WeightW-1:0] weight);
    send_word(CmdAppend, left_edge, weight, CountW'($urandom), FracW'($urandom));
  endtask

  task automatic sample_at(input logic [CountW-1:0] draw, input logic [FracW-1:0] frac);
    send_word(CmdSample, $urandom, WeightW'($urandom), draw, frac);
  endtask

  task automatic send_noise(input logic [1:0] cmd);
    send_word(cmd, $urandom, WeightW'($urandom), CountW'($urandom), FracW'($urandom));
  endtask

  function automatic logic [EdgeW-1:0] pick_edge();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [WeightW-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return WeightW'(1);
      3, 4:    return WeightW'($urandom_range(0, 15));
      default: return WeightW'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [FracW-1:0] pick_frac();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return FracW'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly legal draws, some on the cumulative boundaries, some past the total.
  function automatic logic [CountW-1:0] pick_draw();
    int unsigned k;
    int unsigned mode;
    mode = $urandom_range(0, 19);
    if (sb.used == 0 || mode == 0) return CountW'($urandom_range(0, CountMax));
    if (mode <= 3) begin
      k = $urandom_range(0, sb.used - 1);
      if ($urandom_range(0, 1) == 0 || sb.cum_tab[k] == 0) return sb.cum_tab[k];
      return sb.cum_tab[k] - 1'b1;
    end
    if (mode <= 5 || sb.total == 0) return CountW'($urandom_range(sb.total, CountMax));
    return CountW'($urandom_range(0, sb.total - 1));
  endfunction

  initial begin
    int unsigned      n_bins, n_draws, scen;
    bit               sorted;
    logic [EdgeW-1:0] base_edge, step_edge;
    sb              = new();
    words_sent      = 0;
    quiet_left      = 0;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    cmd_i           = CmdClear;
    bin_left_edge_i = '0;
    bin_weight_i    = '0;
    draw_count_i    = '0;
    draw_fraction_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty table, unused command, boundary draws, extreme edges
    sample_at(0, 16'h8000);
    send_word(CmdUnused, 32'hffff_ffff, 16'hffff, 22'h3f_ffff, 16'hffff);
    append_bin(32'h8000_0000, 16'h0000);
    sample_at(0, 16'h0000);
    send_word(CmdClear, '0, '0, '0, '0);
    append_bin(32'h7fff_ffff, 16'd3);
    append_bin(32'h8000_0000, 16'd0);
    append_bin(32'h8000_0000, 16'd5);
    append_bin(32'h0001_8000, 16'hffff);
    sample_at(0, 16'hffff);
    sample_at(2, 16'h0001);
    sample_at(3, 16'h1234);
    sample_at(7, 16'hffff);
    sample_at(8, 16'h0000);
    sample_at(22'd65542, 16'h4000);
    sample_at(22'd65543, 16'h4000);
    sample_at(22'h3f_ffff, 16'hffff);
    send_word(CmdClear, '1, '1, '1, '1);
    sample_at(0, 16'h0000);
    append_bin(32'h0000_0000, 16'h0001);
    sample_at(0, 16'hffff);
    sample_at(1, 16'hffff);

    // random: mostly clear, build a table, then sample it
    scen = 0;
    while (words_sent < WordTarget) begin
      scen++;
      if (scen % 12 == 1) wait_drain();
      case ($urandom_range(0, 9))
        0:       send_noise(CmdUnused);
        1:       sample_at(pick_draw(), pick_frac());
        default: ;
      endcase
      if ($urandom_range(0, 5) != 0) send_noise(CmdClear);
      case ($urandom_range(0, 9))
        0:       n_bins = $urandom_range(60, 68);
        1, 2:    n_bins = $urandom_range(9, 32);
        default: n_bins = $urandom_range(1, 8);
      endcase
      sorted    = 1'($urandom_range(0, 1));
      base_edge = $urandom;
      step_edge = $urandom_range(1, 32'h0100_0000);
      for (int unsigned k = 0; k < n_bins; k++)
        append_bin(sorted ? base_edge + k * step_edge : pick_edge(), pick_weight());
      n_draws = $urandom_range(2, 12);
      for (int unsigned k = 0; k < n_draws; k++)
        sample_at(pick_draw(), pick_frac());
    end

    wait_drain();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d words in %0d cycles; checked %0d results, %0d samples (%0d open top).",
             words_sent, cycle_count, sb.checked, sb.n_ok, sb.n_top);
    $display("Other outcomes: %0d done, %0d empty table, %0d draw too large, %0d table full.",
             sb.n_done, sb.n_empty, sb.n_range, sb.n_full);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("histogram_bin_sampler: match");
    else
      $display("histogram_bin_sampler: mismatch");
    $finish;
  end

endmodule
